@@ rtl/core/point_series_filter_unit_defines.svh @@
// assertion macros used by the filter unit rtl
`ifndef POINT_SERIES_FILTER_UNIT_DEFINES_SVH
`define POINT_SERIES_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk with the active-low reset masking it
`define PSF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/psf_pkg.sv @@
package psf_pkg;

  // word format
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int MODE_W    = 3;

  // filter modes
  localparam logic [MODE_W-1:0] MODE_PASS  = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_NEG   = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_ABS   = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_POS   = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_DERIV = MODE_W'(4);
  localparam logic [MODE_W-1:0] MODE_INTEG = MODE_W'(5);

  // exact differences and sums need one guard bit
  localparam int MAG_W  = WORD_BITS + 1;
  // dividend of the slope: |dy| scaled by the fraction
  localparam int DVD_W  = MAG_W + FRAC_BITS;
  // product of |avg| and |dx|
  localparam int PROD_W = WORD_BITS + MAG_W;
  // product after dropping the fraction
  localparam int M_W    = PROD_W - FRAC_BITS;
  // running sum plus signed term, with room to detect overflow
  localparam int SUM_W  = M_W + 2;

  localparam int DIV_CNT_W = $clog2(DVD_W);
  localparam int MUL_CNT_W = $clog2(MAG_W);

  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } psf_seq_stat_t;

endpackage

@@ rtl/core/psf_in_if.sv @@
interface psf_in_if;
  import psf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] point_x;
  logic [WORD_BITS-1:0] point_y;
  logic                 set_end;

  modport source (output valid, output point_x, output point_y, output set_end,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input set_end,
                  output ready);
endinterface

@@ rtl/core/psf_out_if.sv @@
interface psf_out_if;
  import psf_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] out_x;
  logic [WORD_BITS-1:0] out_y;
  logic                 out_last;
  logic                 out_error;

  modport source (output valid, output out_x, output out_y, output out_last,
                  output out_error, input ready);
  modport sink   (input valid, input out_x, input out_y, input out_last,
                  input out_error, output ready);
endinterface

@@ rtl/core/psf_div.sv @@
module psf_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [psf_pkg::MAG_W-1:0]           num,
  input  logic [psf_pkg::MAG_W-1:0]           den,
  output psf_pkg::psf_seq_stat_t              stat,
  output logic [psf_pkg::WORD_BITS-1:0]       quo,
  output logic                                ovf
);
  import psf_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [MAG_W-1:0]     den_r;
  logic [MAG_W-1:0]     rem_r;
  logic [MAG_W-1:0]     rem_nxt;
  logic [WORD_BITS-1:0] q_r;
  logic                 ovf_r;
  logic [MAG_W:0]       trial;
  logic [MAG_W:0]       diff;
  logic                 q_bit;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_W-1]};
    diff    = trial - {1'b0, den_r};
    q_bit   = trial >= {1'b0, den_r};
    rem_nxt = q_bit ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DVD_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // datapath, quotient bits leaving the word mark overflow
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= {num, {FRAC_BITS{1'b0}}};
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[WORD_BITS-2:0], q_bit};
      ovf_r <= ovf_r | q_r[WORD_BITS-1];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign quo       = q_r;
  assign ovf       = ovf_r;
endmodule

@@ rtl/core/psf_mul.sv @@
module psf_mul (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [psf_pkg::WORD_BITS-1:0]   mcand,
  input  logic [psf_pkg::MAG_W-1:0]       mplier,
  output psf_pkg::psf_seq_stat_t          stat,
  output logic [psf_pkg::PROD_W-1:0]      prod
);
  import psf_pkg::*;

  logic                 busy_r;
  logic [MUL_CNT_W-1:0] cnt_r;
  logic [WORD_BITS-1:0] mcand_r;
  logic [PROD_W-1:0]    acc_r;
  logic [WORD_BITS:0]   part;

  // add the multiplicand into the upper half when the low multiplier bit is set
  always_comb begin
    part = {1'b0, acc_r[PROD_W-1:MAG_W]};
    if (acc_r[0]) part = part + {1'b0, mcand_r};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= MUL_CNT_W'(MAG_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) busy_r <= 1'b0;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // shift-add accumulator, multiplier bits shift out at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      acc_r   <= {{WORD_BITS{1'b0}}, mplier};
    end else if (busy_r) begin
      acc_r <= {part, acc_r[MAG_W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign prod      = acc_r;
endmodule

@@ rtl/core/point_series_filter_unit.sv @@
// pass, negate, absolute, positive-only and zero-dx derivative go from idle straight
//   to done; integrate and derivative pass through prepare, run and finish, where the
//   serial divider works through 49 bit steps and the serial multiplier through 33
// a new word is taken only in idle, once the result word of the last one is loaded;
//   a first point with no result stays idle; done waits until the previous output word is taken
// reset: synchronous active-low, clears mode, held point and running sum
`include "point_series_filter_unit_defines.svh"

module point_series_filter_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  psf_in_if.sink                         in_ch,
  psf_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [psf_pkg::MODE_W-1:0]     cfg_wdata
);
  import psf_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_RUN  = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  // long operations
  localparam logic OP_DIV = 1'b0;
  localparam logic OP_MUL = 1'b1;

  function automatic logic [MAG_W-1:0] abs_mag(input logic [MAG_W-1:0] v);
    return v[MAG_W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [2:0]           state_r, state_nxt;
  logic                 op_r;
  logic [MODE_W-1:0]    filter_mode_r;
  logic [WORD_BITS-1:0] prev_x_r, prev_y_r, area_sum_r;
  logic                 have_prev_r;
  logic [MAG_W-1:0]     dx_r, dy_r, ysum_r;
  logic                 neg_r;
  logic [WORD_BITS-1:0] res_x_r, res_y_r;
  logic                 res_last_r, res_err_r;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_x_r, out_y_r;
  logic                 out_last_r, out_error_r;

  logic                 in_fire, out_load;
  logic [MAG_W-1:0]     dx_nxt, dy_nxt, ysum_nxt;
  logic [WORD_BITS-1:0] ry_nxt, rx_nxt;
  logic                 err_nxt, emit_nxt, long_nxt, op_nxt;
  logic [WORD_BITS-1:0] neg_y;
  logic                 y_is_min;

  logic [MAG_W-1:0]     avg_full, avg_s, avg_mag, dx_mag, dy_mag;
  logic                 unit_start;
  psf_seq_stat_t        div_stat, mul_stat;
  logic [WORD_BITS-1:0] div_quo;
  logic                 div_ovf;
  logic [PROD_W-1:0]    mul_prod;

  logic                 q_over;
  logic [WORD_BITS-1:0] slope;
  logic [M_W:0]         term;
  logic [SUM_W-1:0]     sum_w;
  logic                 sum_hi, sum_lo;
  logic [WORD_BITS-1:0] area_nxt;

  assign in_fire = in_ch.valid && in_ch.ready;

  // differences to the held point, exact with a guard bit
  always_comb begin
    dx_nxt   = {in_ch.point_x[WORD_BITS-1], in_ch.point_x}
             - {prev_x_r[WORD_BITS-1], prev_x_r};
    dy_nxt   = {in_ch.point_y[WORD_BITS-1], in_ch.point_y}
             - {prev_y_r[WORD_BITS-1], prev_y_r};
    ysum_nxt = {in_ch.point_y[WORD_BITS-1], in_ch.point_y}
             + {prev_y_r[WORD_BITS-1], prev_y_r};
  end

  // per-point modes finish at once; pair modes start a serial unit, bar a zero-dx slope
  always_comb begin
    y_is_min = in_ch.point_y == WORD_MIN;
    neg_y    = y_is_min ? WORD_MAX : (~in_ch.point_y + 1'b1);
    rx_nxt   = in_ch.point_x;
    ry_nxt   = in_ch.point_y;
    err_nxt  = 1'b0;
    emit_nxt = 1'b1;
    long_nxt = 1'b0;
    op_nxt   = OP_DIV;
    case (filter_mode_r)
      MODE_NEG: begin
        ry_nxt  = neg_y;
        err_nxt = y_is_min;
      end
      MODE_ABS: begin
        if (in_ch.point_y[WORD_BITS-1]) begin
          ry_nxt  = neg_y;
          err_nxt = y_is_min;
        end
      end
      MODE_POS: begin
        if (in_ch.point_y[WORD_BITS-1]) ry_nxt = '0;
      end
      MODE_DERIV: begin
        rx_nxt = prev_x_r;
        if (!have_prev_r) begin
          emit_nxt = 1'b0;
        end else if (dx_nxt == '0) begin
          ry_nxt  = dy_nxt[MAG_W-1] ? WORD_MIN : WORD_MAX;
          err_nxt = 1'b1;
        end else begin
          long_nxt = 1'b1;
        end
      end
      MODE_INTEG: begin
        rx_nxt = prev_x_r;
        if (!have_prev_r) emit_nxt = 1'b0;
        else begin
          long_nxt = 1'b1;
          op_nxt   = OP_MUL;
        end
      end
      MODE_PASS: ;
      default: ;
    endcase
  end

  // operand magnitudes, average truncated toward zero
  always_comb begin
    avg_full   = ysum_r + {{(MAG_W-1){1'b0}}, ysum_r[MAG_W-1]};
    avg_s      = {avg_full[MAG_W-1], avg_full[MAG_W-1:1]};
    avg_mag    = abs_mag(avg_s);
    dx_mag     = abs_mag(dx_r);
    dy_mag     = abs_mag(dy_r);
    unit_start = state_r == ST_PREP;
  end

  psf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start && (op_r == OP_DIV)),
    .num   (dy_mag),
    .den   (dx_mag),
    .stat  (div_stat),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  psf_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (unit_start && (op_r == OP_MUL)),
    .mcand  (avg_mag[WORD_BITS-1:0]),
    .mplier (dx_mag),
    .stat   (mul_stat),
    .prod   (mul_prod)
  );

  // slope: saturate at the largest magnitude of the result sign
  always_comb begin
    q_over = div_ovf || (neg_r ? (div_quo[WORD_BITS-1] && (|div_quo[WORD_BITS-2:0]))
                               : div_quo[WORD_BITS-1]);
    if (q_over) slope = neg_r ? WORD_MIN : WORD_MAX;
    else        slope = neg_r ? (~div_quo + 1'b1) : div_quo;
  end

  // trapezoid: signed term added to the running sum, then saturated
  always_comb begin
    term   = neg_r ? (~{1'b0, mul_prod[PROD_W-1:FRAC_BITS]} + 1'b1)
                   : {1'b0, mul_prod[PROD_W-1:FRAC_BITS]};
    sum_w  = {{(SUM_W-WORD_BITS){area_sum_r[WORD_BITS-1]}}, area_sum_r}
           + {term[M_W], term};
    sum_hi = !sum_w[SUM_W-1] && (|sum_w[SUM_W-2:WORD_BITS-1]);
    sum_lo = sum_w[SUM_W-1] && !(&sum_w[SUM_W-2:WORD_BITS-1]);
    if (sum_hi)      area_nxt = WORD_MAX;
    else if (sum_lo) area_nxt = WORD_MIN;
    else             area_nxt = sum_w[WORD_BITS-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && emit_nxt) state_nxt = long_nxt ? ST_PREP : ST_DONE;
      end
      ST_PREP: state_nxt = ST_RUN;
      ST_RUN: begin
        if (div_stat.done || mul_stat.done) state_nxt = ST_FIN;
      end
      ST_FIN: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      filter_mode_r <= MODE_PASS;
      have_prev_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) filter_mode_r <= cfg_wdata;
      if (in_fire) have_prev_r <= !in_ch.set_end;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // held point and running sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r   <= '0;
      prev_y_r   <= '0;
      area_sum_r <= '0;
    end else begin
      if (in_fire) begin
        prev_x_r <= in_ch.point_x;
        prev_y_r <= in_ch.point_y;
        if (!have_prev_r) area_sum_r <= '0;
      end
      if (state_r == ST_FIN && op_r == OP_MUL) area_sum_r <= area_nxt;
    end
  end

  // word capture and result assembly
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r       <= op_nxt;
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      ysum_r     <= ysum_nxt;
      res_x_r    <= rx_nxt;
      res_y_r    <= ry_nxt;
      res_last_r <= in_ch.set_end;
      res_err_r  <= err_nxt;
    end
    if (state_r == ST_PREP) begin
      neg_r <= (op_r == OP_DIV) ? (dy_r[MAG_W-1] ^ dx_r[MAG_W-1])
                                : (avg_s[MAG_W-1] ^ dx_r[MAG_W-1]);
    end
    if (state_r == ST_FIN) begin
      if (op_r == OP_DIV) begin
        res_y_r   <= slope;
        res_err_r <= q_over;
      end else begin
        res_y_r   <= area_nxt;
        res_err_r <= sum_hi || sum_lo;
      end
    end
    if (out_load) begin
      out_x_r     <= res_x_r;
      out_y_r     <= res_y_r;
      out_last_r  <= res_last_r;
      out_error_r <= res_err_r;
    end
  end

  assign in_ch.ready      = state_r == ST_IDLE;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.out_last  = out_last_r;
  assign out_ch.out_error = out_error_r;

  // a serial unit is working whenever the sequencer waits on one
  `PSF_ASSERT_IMP(a_run_busy, state_r == ST_RUN, div_stat.busy || mul_stat.busy, "no busy unit")
  // a new result word only appears after the sequencer finished an item
  `PSF_ASSERT_IMP(a_load_src, $rose(out_valid_r), $past(state_r == ST_DONE), "bad load")
  // the two serial units never run together
  `PSF_ASSERT_IMP(a_one_unit, 1'b1, !(div_stat.busy && mul_stat.busy), "both units busy")
  // the end of a set drops the held point
  `PSF_ASSERT_NXT(a_set_end, in_fire && in_ch.set_end, !have_prev_r, "point held past set end")
endmodule
